@@ rtl/lphs_pkg.sv @@
`default_nettype none

package lphs_pkg;

    // Request operations.
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_PROBE  = 2'd0;
    localparam t_opcode OP_INSERT = 2'd1;
    localparam t_opcode OP_DELETE = 2'd2;
    // The spare code behaves as a probe.
    localparam t_opcode OP_SPARE  = 2'd3;

    // Result status codes.
    typedef logic [2:0] t_status;
    localparam t_status ST_FOUND     = 3'd0;
    localparam t_status ST_INSERTED  = 3'd1;
    localparam t_status ST_NOT_FOUND = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_REMOVED   = 3'd4;

    // Register map.
    localparam int          ADDR_BITS         = 3;
    localparam logic [2:0]  REG_FILL_LIMIT    = 3'd0;
    localparam logic [9:0]  FILL_LIMIT_RESET  = 10'd512;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SHIFT_READ,
        S_SHIFT_CHECK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/linear_probe_hash_set_top.sv @@
// Open-addressed hash set with linear probing and backward-shift deletion.
// Input channel (i_valid/o_ready) carries opcode, key and key hash; output
// channel (o_valid/i_ready) returns status, slot index and key count.
// Each request yields exactly one result.
// The home slot is the low bits of the hash (SLOTS is a power of two);
// probing walks downward with wrap until the key or an empty slot is met.
// Every slot visited costs a memory read state and then a check state, as
// the single table memory has one read port, and that port is registered.
// A delete goes on walking the slots below the removed key to close the gap.
// One request is in flight at a time; the next is taken once the result
// has been registered, even if that result still waits for the receiver.
// A stalled receiver holds the result and, behind it, one finished item.
// After reset the table is swept clear, one slot per cycle, across all SLOTS
// slots; no request is taken during that sweep, though the fill-limit
// register can be written at any time through the APB-style port.
`default_nettype none

module linear_probe_hash_set_top
    import lphs_pkg::*;
#(
    parameter int SLOTS    = 1024,
    parameter int KEY_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [31:0]          i_key,
    input  wire logic [31:0]          i_key_hash,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [2:0]           o_status,
    output logic      [9:0]           o_slot_index,
    output logic      [9:0]           o_key_count,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    localparam int AW    = $clog2(SLOTS);
    localparam int WIDTH = 1 + AW + KEY_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    t_opcode             r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [AW-1:0]       r_home, n_home;
    logic [AW-1:0]       r_s, n_s;
    logic [AW-1:0]       r_ss, n_ss;
    logic [AW-1:0]       r_where, n_where;
    t_status             r_res, n_res;
    logic [AW-1:0]       r_count, n_count;
    logic                r_ovalid, n_ovalid;
    logic [2:0]          r_ostatus, n_ostatus;
    logic [9:0]          r_oslot, n_oslot;
    logic [9:0]          r_ocount, n_ocount;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WIDTH-1:0]    mem_wdata;
    logic [WIDTH-1:0]    mem_rdata;
    logic [9:0]          fill_limit;

    logic                rd_used;
    logic [AW-1:0]       rd_home;
    logic [KEY_BITS-1:0] rd_key;
    logic [63:0]         key_ext;
    logic [AW-1:0]       s_down;
    logic                full;
    logic                move;

    lphs_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fill_limit (fill_limit)
    );

    lphs_mem #(
        .DEPTH (SLOTS),
        .AW    (AW),
        .WIDTH (WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_s),
        .o_rdata (mem_rdata)
    );

    // Fields of the slot word read back.
    assign rd_used = mem_rdata[WIDTH-1];
    assign rd_home = mem_rdata[KEY_BITS +: AW];
    assign rd_key  = mem_rdata[KEY_BITS-1:0];
    assign key_ext = {32'd0, i_key};
    assign s_down  = (r_s == '0) ? LAST_SLOT : r_s - 1'b1;

    // Refusal of an insert: limit reached or only one hole left.
    assign full = (32'(r_count) >= 32'(fill_limit)) || (r_count >= LAST_SLOT);

    // Whether the entry at r_s may move up into the gap at r_ss.
    always_comb begin
        if (r_s < r_ss) begin
            move = (rd_home >= r_ss) || (rd_home < r_s);
        end else if (r_s > r_ss) begin
            move = (rd_home >= r_ss) && (rd_home < r_s);
        end else begin
            move = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_home    <= n_home;
        r_s       <= n_s;
        r_ss      <= n_ss;
        r_where   <= n_where;
        r_res     <= n_res;
        r_ostatus <= n_ostatus;
        r_oslot   <= n_oslot;
        r_ocount  <= n_ocount;
    end

    // Sequencer: clear sweep, probe walk, insert, backward shift, result.
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_op      = r_op;
        n_key     = r_key;
        n_home    = r_home;
        n_s       = r_s;
        n_ss      = r_ss;
        n_where   = r_where;
        n_res     = r_res;
        n_count   = r_count;
        n_ovalid  = r_ovalid && !i_ready;
        n_ostatus = r_ostatus;
        n_oslot   = r_oslot;
        n_ocount  = r_ocount;
        mem_we    = 1'b0;
        mem_waddr = r_s;
        mem_wdata = '0;
        o_ready   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op    = i_opcode;
                    n_key   = key_ext[KEY_BITS-1:0];
                    n_home  = i_key_hash[AW-1:0];
                    n_s     = i_key_hash[AW-1:0];
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (rd_used && rd_key != r_key) begin
                    n_s     = s_down;
                    n_state = S_READ;
                end else begin
                    n_where = r_s;
                    n_state = S_DONE;
                    case (r_op)
                        OP_INSERT: begin
                            if (rd_used) begin
                                n_res = ST_FOUND;
                            end else if (full) begin
                                n_res = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_s;
                                mem_wdata = {1'b1, r_home, r_key};
                                n_count   = r_count + 1'b1;
                                n_res     = ST_INSERTED;
                            end
                        end
                        OP_DELETE: begin
                            if (rd_used) begin
                                n_ss    = r_s;
                                n_s     = s_down;
                                n_state = S_SHIFT_READ;
                            end else begin
                                n_res = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_res = rd_used ? ST_FOUND : ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SHIFT_READ: begin
                n_state = S_SHIFT_CHECK;
            end
            S_SHIFT_CHECK: begin
                if (!rd_used) begin
                    // End of the chain: the gap becomes empty.
                    mem_we    = 1'b1;
                    mem_waddr = r_ss;
                    mem_wdata = '0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_res   = ST_REMOVED;
                    n_state = S_DONE;
                end else begin
                    if (move) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_ss;
                        mem_wdata = mem_rdata;
                        n_ss      = r_s;
                    end
                    n_s     = s_down;
                    n_state = S_SHIFT_READ;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res;
                    n_oslot   = 10'(32'(r_where));
                    n_ocount  = 10'(32'(r_count));
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_slot_index = r_oslot;
    assign o_key_count  = r_ocount;

    // The count never reaches the table size, so a hole always remains.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_SLOT)
        else $error("key count exceeds table capacity");

    // The count moves by at most one per step.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1))
        else $error("key count jumped");

    // No table write while waiting for a request.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("table written while idle");

    // A transfer always starts a table read.
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_READ))
        else $error("request transfer did not start a probe");

endmodule

`default_nettype wire

@@ rtl/lphs_mem.sv @@
`default_nettype none

module lphs_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int WIDTH = 43
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/lphs_cfg.sv @@
`default_nettype none

module lphs_cfg
    import lphs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output logic      [9:0]           o_fill_limit
);

    logic [9:0] r_fill_limit;

    // Register write on the access phase of a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= FILL_LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr == REG_FILL_LIMIT) begin
            r_fill_limit <= pwdata[9:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (paddr == REG_FILL_LIMIT) begin
            prdata = {22'd0, r_fill_limit};
        end
    end

    assign pready       = 1'b1;
    assign o_fill_limit = r_fill_limit;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
    import lphs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = 1024;

    // Result of one request as the block should report it.
    typedef struct packed {
        t_status    status;
        logic [9:0] slot;
        logic [9:0] count;
    } t_lookup_result;

    // Scoreboard: holds its own copy of the table and the expected results.
    class hash_set_scoreboard;
        logic [31:0] key_store [NSLOTS];
        logic [9:0]  home_store [NSLOTS];
        bit          used [NSLOTS];
        int unsigned held;
        int unsigned limit;
        t_lookup_result pending_results[$];
        int unsigned errors;
        int unsigned status_seen [5];

        function void clear();
            foreach (used[i]) begin
                used[i] = 0;
                key_store[i] = '0;
                home_store[i] = '0;
            end
            held = 0;
            limit = FILL_LIMIT_RESET;
        endfunction

        // Walk the chain downward from home; returns hit, and the slot in where.
        function bit locate(logic [31:0] k, logic [9:0] home, output logic [9:0] where);
            logic [9:0] s;
            s = home;
            for (int n = 0; n < NSLOTS; n++) begin
                if (!used[s]) begin
                    where = s;
                    return 0;
                end
                if (key_store[s] == k) begin
                    where = s;
                    return 1;
                end
                s = s - 10'd1;
            end
            where = home;
            return 0;
        endfunction

        // Backward-shift removal that closes the gap left at hole.
        function void close_gap(logic [9:0] hole);
            logic [9:0] dst, src, h;
            bit mv;
            dst = hole;
            src = hole;
            for (int n = 0; n < NSLOTS; n++) begin
                src = src - 10'd1;
                if (!used[src]) break;
                h = home_store[src];
                if (src < dst) mv = (h >= dst) || (h < src);
                else if (src > dst) mv = (h >= dst) && (h < src);
                else mv = 0;
                if (mv) begin
                    key_store[dst] = key_store[src];
                    home_store[dst] = home_store[src];
                    dst = src;
                end
            end
            used[dst] = 0;
        endfunction

        function void note_request(t_opcode op, logic [31:0] k, logic [31:0] hash);
            logic [9:0] home, where;
            bit hit;
            t_lookup_result r;
            home = hash[9:0];
            hit = locate(k, home, where);
            if (op == OP_INSERT) begin
                if (hit) r.status = ST_FOUND;
                else if (held >= limit || held >= NSLOTS - 1 || used[where])
                    r.status = ST_FULL;
                else begin
                    key_store[where] = k;
                    home_store[where] = home;
                    used[where] = 1;
                    held++;
                    r.status = ST_INSERTED;
                end
            end else if (op == OP_DELETE) begin
                if (hit) begin
                    close_gap(where);
                    if (held > 0) held--;
                    r.status = ST_REMOVED;
                end else r.status = ST_NOT_FOUND;
            end else begin
                r.status = hit ? ST_FOUND : ST_NOT_FOUND;
            end
            r.slot = where;
            r.count = held[9:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(t_status st, logic [9:0] slot, logic [9:0] cnt);
            t_lookup_result e;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d slot %0d count %0d", st, slot, cnt);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (st <= ST_REMOVED) status_seen[st]++;
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (slot !== e.slot) begin
                $error("slot_index: expected %0d, got %0d", e.slot, slot);
                errors++;
            end
            if (cnt !== e.count) begin
                $error("key_count: expected %0d, got %0d", e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_ready = 0;
    logic [1:0] i_opcode = '0;
    logic [31:0] i_key = '0, i_key_hash = '0;
    logic o_ready, o_valid;
    logic [2:0] o_status;
    logic [9:0] o_slot_index, o_key_count;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    linear_probe_hash_set_top dut (.*);

    always #6 i_clk = ~i_clk;

    hash_set_scoreboard sb = new();
    bit hold_off = 0;
    int unsigned sent = 0;
    logic [31:0] live_keys[$];

    // Register write with a setup phase and then an access phase.
    task automatic write_reg(logic [ADDR_BITS-1:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= value; penable <= 0;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_FILL_LIMIT) sb.limit = value[9:0];
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // One request transfer; the scoreboard notes it once accepted.
    task automatic send_request(t_opcode op, logic [31:0] k, logic [31:0] hash);
        @(negedge i_clk);
        i_valid <= 1; i_opcode <= op; i_key <= k; i_key_hash <= hash;
        do @(posedge i_clk); while (!(o_ready === 1'b1));
        sb.note_request(op, k, hash);
        sent++;
        if (op == OP_INSERT) live_keys.push_back(k);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    // Random gap length for bursty sending.
    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Random request with keys mostly from a small pool and clustered hashes.
    task automatic random_request(int unsigned pool, int unsigned span);
        t_opcode op;
        logic [31:0] k, h;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) op = OP_INSERT;
        else if (r < 70) op = OP_DELETE;
        else if (r < 95) op = OP_PROBE;
        else op = OP_SPARE;
        if (live_keys.size() != 0 && $urandom_range(0, 1))
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else if ($urandom_range(0, 9) == 0)
            k = $urandom();
        else
            k = $urandom_range(0, pool);
        // Hash follows key so the same key keeps one home slot.
        h = {k[21:0] ^ 22'h2A5A5, 10'd0} | ((k * 32'd7 + 32'd3) % span);
        if (h[9:0] >= span) h[9:0] = 10'(h[9:0] % span);
        if (k[31]) h[9:0] = 10'(10'd1023 - h[9:0] % span);
        if (live_keys.size() > 64) live_keys.delete(0);
        send_request(op, k, h);
    endtask

    // Receiver: own stall pattern, plus a long hold-off on request.
    initial begin
        int unsigned mode;
        forever begin
            @(negedge i_clk);
            if (hold_off) i_ready <= 0;
            else begin
                mode = 32'(($time / 3000) % 3);
                if (mode == 0) i_ready <= 1;
                else i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Result checking at the rising edge.
    always @(posedge i_clk)
        if (i_rst_n && o_valid === 1'b1 && i_ready)
            sb.check_result(o_status, o_slot_index, o_key_count);

    // Long hold-off counted in receiver cycles while the sender keeps offering.
    task automatic long_hold_off();
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            repeat (20) random_request(200, 64);
        join
    endtask

    initial begin
        sb.clear();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // Directed: extremes, every operation, chains across the wrap.
        write_reg(REG_FILL_LIMIT, 3);
        send_request(OP_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_INSERT, 32'h8000_0001, 32'hFFFF_FC00);
        send_request(OP_INSERT, 32'h5555_5555, 32'h0);
        send_request(OP_INSERT, 32'h0, 32'hAAAA_AAAA);
        send_request(OP_SPARE, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_PROBE, 32'h8000_0001, 32'h0);
        send_request(OP_DELETE, 32'h0, 32'h0);
        send_request(OP_PROBE, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_PROBE, 32'h8000_0001, 32'h0);
        send_request(OP_DELETE, 32'hAAAA_AAAA, 32'h5555_57FF);
        wait_drained();
        write_reg(REG_FILL_LIMIT, 0);
        send_request(OP_INSERT, 32'h1234_5678, 32'h3FF);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_DELETE, 32'h8000_0001, 32'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        wait_drained();

        // Random phases across several limits.
        write_reg(REG_FILL_LIMIT, 1023);
        for (int i = 0; i < 300; i++) begin
            random_request(600, 1024);
            maybe_gap();
        end
        long_hold_off();
        wait_drained();
        write_reg(REG_FILL_LIMIT, 40);
        for (int i = 0; i < 300; i++) begin
            random_request(120, 48);
            maybe_gap();
        end
        wait_drained();
        write_reg(REG_FILL_LIMIT, 1);
        for (int i = 0; i < 60; i++) random_request(10, 8);
        wait_drained();
        write_reg(REG_FILL_LIMIT, 512);
        for (int i = 0; i < 300; i++) begin
            random_request(80, 16);
            maybe_gap();
        end
        long_hold_off();
        wait_drained();

        $display("Sent %0d requests over fill limits 0, 1, 3, 40, 512 and 1023.", sent);
        $display("Statuses seen: found %0d, inserted %0d, not found %0d, full %0d, removed %0d.",
                 sb.status_seen[ST_FOUND], sb.status_seen[ST_INSERTED],
                 sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_REMOVED]);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Overall limit on the run.
    initial begin
        #200ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/lphs_pkg.sv
rtl/lphs_mem.sv
rtl/lphs_cfg.sv
rtl/linear_probe_hash_set_top.sv
tb/tb.sv
